### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion shorthands used by the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, masked while rst is high
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, masked while rst is high
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### rtl/core/ssdm_pkg.sv
// ----------------------------------------------------------------------------
// ssdm_pkg
// shared widths, register map, digit split and segment table for the
// four-digit multiplexed seven-segment display driver
// ----------------------------------------------------------------------------
package ssdm_pkg;

   // display geometry and field widths
   localparam int DIGIT_COUNT = 4;
   localparam int DIGIT_IDX_W = $clog2(DIGIT_COUNT);
   localparam int NUMBER_W    = 14;
   localparam int SEG_W       = 8;
   localparam int TICK_W      = 8;
   localparam int BCD_W       = 4;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   // register reset values
   localparam logic [TICK_W-1:0] DUTY_RESET   = 8'd100;
   localparam logic [TICK_W-1:0] PERIOD_RESET = 8'd250;

   // largest value that fits on four digits
   localparam logic [NUMBER_W-1:0] MAX_NUMBER = 14'd9999;

   // reciprocal multipliers, exact for every value up to MAX_NUMBER
   localparam int PROD_W      = 30;
   localparam int RECIP_1000  = 8389;
   localparam int SHIFT_1000  = 23;
   localparam int RECIP_100   = 5243;
   localparam int SHIFT_100   = 19;
   localparam int RECIP_10    = 52429;
   localparam int SHIFT_10    = 19;
   localparam int RADIX       = 10;

   // register word addresses (paddr bit 2)
   typedef enum logic [0:0] {
      REG_DUTY_TIME    = 1'b0,
      REG_ROUND_PERIOD = 1'b1
   } reg_index_type;

   typedef logic [DIGIT_COUNT-1:0][BCD_W-1:0] digit_set_type;
   typedef logic [DIGIT_COUNT-1:0][SEG_W-1:0] pattern_set_type;

   // input item mode codes
   typedef enum logic {
      MODE_LOAD    = 1'b0,
      MODE_COMPARE = 1'b1
   } mode_type;

   // segment pattern for one decimal digit, a in bit 7, dp in bit 0
   function automatic logic [SEG_W-1:0] seg_pattern(input logic [BCD_W-1:0] d);
      logic [SEG_W-1:0] p;
      case (d)
         4'd0:    p = 8'hFC;
         4'd1:    p = 8'h60;
         4'd2:    p = 8'hDA;
         4'd3:    p = 8'hF2;
         4'd4:    p = 8'h66;
         4'd5:    p = 8'hB6;
         4'd6:    p = 8'hBE;
         4'd7:    p = 8'hE0;
         4'd8:    p = 8'hFE;
         4'd9:    p = 8'hF6;
         default: p = 8'h00;
      endcase
      return p;
   endfunction

   // split a saturated number into thousands, hundreds, tens and units;
   // the three quotients are formed in parallel by reciprocal multiplies
   function automatic digit_set_type split_number(input logic [NUMBER_W-1:0] n);
      logic [PROD_W-1:0]   p1000;
      logic [PROD_W-1:0]   p100;
      logic [PROD_W-1:0]   p10;
      logic [BCD_W-1:0]    q1000;
      logic [6:0]          q100;
      logic [9:0]          q10;
      logic [6:0]          r100;
      logic [9:0]          r10;
      logic [NUMBER_W-1:0] r1;
      digit_set_type       d;
      p1000 = PROD_W'(n) * PROD_W'(RECIP_1000);
      p100  = PROD_W'(n) * PROD_W'(RECIP_100);
      p10   = PROD_W'(n) * PROD_W'(RECIP_10);
      q1000 = BCD_W'(p1000 >> SHIFT_1000);
      q100  = 7'(p100 >> SHIFT_100);
      q10   = 10'(p10 >> SHIFT_10);
      r100  = q100 - 7'(7'(q1000) * 7'(RADIX));
      r10   = q10 - 10'(10'(q100) * 10'(RADIX));
      r1    = n - NUMBER_W'(NUMBER_W'(q10) * NUMBER_W'(RADIX));
      d[0]  = q1000;
      d[1]  = r100[BCD_W-1:0];
      d[2]  = r10[BCD_W-1:0];
      d[3]  = r1[BCD_W-1:0];
      return d;
   endfunction

endpackage

### rtl/core/ssdm_req_if.sv
// ----------------------------------------------------------------------------
// ssdm_req_if
// input channel: load or compare-event items with valid/ready handshake
// ----------------------------------------------------------------------------
interface ssdm_req_if import ssdm_pkg::*; ();

   logic                valid;
   logic                ready;
   logic                mode;
   logic [NUMBER_W-1:0] number;

   modport source (output valid, output mode, output number, input ready);
   modport sink   (input valid, input mode, input number, output ready);

endinterface

### rtl/core/ssdm_rsp_if.sv
// ----------------------------------------------------------------------------
// ssdm_rsp_if
// result channel: segment drive, digit enables and next compare value
// ----------------------------------------------------------------------------
interface ssdm_rsp_if import ssdm_pkg::*; ();

   logic                   valid;
   logic                   ready;
   logic [SEG_W-1:0]       segment_lines;
   logic [DIGIT_COUNT-1:0] digit_enables_n;
   logic [TICK_W-1:0]      next_compare;

   modport source (output valid, output segment_lines, output digit_enables_n,
                   output next_compare, input ready);
   modport sink   (input valid, input segment_lines, input digit_enables_n,
                   input next_compare, output ready);

endinterface

### rtl/core/seven_segment_display_multiplexer_unit.sv
// ----------------------------------------------------------------------------
// seven_segment_display_multiplexer_unit
// four-digit multiplexed seven-segment display driver
//
// Items arrive on req_ch. Mode 0 loads a number (saturated at 9999) whose
// digit patterns become visible at the next scan start. Mode 1 is a timer
// compare event; on and off events alternate, the first one after reset
// being an off event. Every item gives exactly one result on rsp_ch: the
// segment drive, the active-low digit enables and the next compare value.
// duty_time (byte address 0) and round_period (byte address 4) are written
// over the csr_ APB port, which has no wait states.
// An item is registered in the input register on acceptance and then
// moves into the result register; the block takes one item per cycle
// while rsp_ch does not stall. If rsp_ch stalls the result holds and one
// more item can still be taken into the input register; after that
// req_ch.ready drops until the result is taken. Reset clears both stages,
// shows all digits off and restores the register defaults.
// ----------------------------------------------------------------------------
module seven_segment_display_multiplexer_unit import ssdm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   ssdm_req_if.sink              req_ch,
   ssdm_rsp_if.source            rsp_ch,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   // configuration registers
   logic [TICK_W-1:0]      duty_ff, duty_in;
   logic [TICK_W-1:0]      period_ff, period_in;

   // input stage
   logic                   stage_valid_ff, stage_valid_in;
   logic                   stage_mode_ff;
   logic [NUMBER_W-1:0]    stage_number_ff;

   // result stage and display state
   logic                   out_valid_ff, out_valid_in;
   logic                   turn_on_next_ff, turn_on_next_in;
   logic [TICK_W-1:0]      round_time_ff, round_time_in;
   logic [DIGIT_IDX_W-1:0] digit_index_ff, digit_index_in;
   pattern_set_type        pending_ff, pending_in;
   pattern_set_type        shown_ff, shown_in;
   logic [SEG_W-1:0]       segment_ff, segment_in;
   logic [DIGIT_COUNT-1:0] digit_ff, digit_in;
   logic [TICK_W-1:0]      compare_ff, compare_in;

   logic                   accept;
   logic                   advance;
   logic                   csr_write;
   reg_index_type          csr_index;
   logic [NUMBER_W-1:0]    sat_number;
   digit_set_type          digits;

   // handshake control
   assign advance = stage_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !reset && (!stage_valid_ff || advance);
   assign accept = req_ch.valid && req_ch.ready;

   // register port
   assign csr_pready = 1'b1;
   assign csr_index  = reg_index_type'(csr_paddr[2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      duty_in   = duty_ff;
      period_in = period_ff;
      if (csr_write) begin
         case (csr_index)
            REG_DUTY_TIME:    duty_in   = csr_pwdata[TICK_W-1:0];
            REG_ROUND_PERIOD: period_in = csr_pwdata[TICK_W-1:0];
            default:          duty_in   = duty_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_DUTY_TIME:    csr_prdata = CSR_DATA_W'(duty_ff);
         REG_ROUND_PERIOD: csr_prdata = CSR_DATA_W'(period_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // saturate and split a number to load
   assign sat_number = (stage_number_ff > MAX_NUMBER) ? MAX_NUMBER : stage_number_ff;
   assign digits     = split_number(sat_number);

   // display state update for the item in the input stage
   always_comb begin
      stage_valid_in  = accept || (stage_valid_ff && !advance);
      out_valid_in    = advance || (out_valid_ff && !rsp_ch.ready);
      turn_on_next_in = turn_on_next_ff;
      round_time_in   = round_time_ff;
      digit_index_in  = digit_index_ff;
      pending_in      = pending_ff;
      shown_in        = shown_ff;
      segment_in      = segment_ff;
      digit_in        = digit_ff;
      compare_in      = compare_ff;
      if (advance) begin
         case (mode_type'(stage_mode_ff))
            MODE_LOAD: begin
               for (int i = 0; i < DIGIT_COUNT; i++) begin
                  pending_in[i] = seg_pattern(digits[i]);
               end
            end
            MODE_COMPARE: begin
               if (turn_on_next_ff) begin
                  // on event: start the round and light the current digit
                  turn_on_next_in = 1'b0;
                  round_time_in   = round_time_ff + period_ff;
                  compare_in      = round_time_ff + duty_ff;
                  if (digit_index_ff == '0) begin
                     shown_in = pending_ff;
                  end
                  segment_in     = shown_in[digit_index_ff];
                  digit_in       = digit_ff & ~(DIGIT_COUNT'(1) << digit_index_ff);
                  digit_index_in = digit_index_ff + 1'b1;
               end else begin
                  // off event: blank everything until the next round start
                  turn_on_next_in = 1'b1;
                  compare_in      = round_time_ff;
                  segment_in      = '0;
                  digit_in        = '1;
               end
            end
            default: turn_on_next_in = turn_on_next_ff;
         endcase
      end
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         duty_ff         <= DUTY_RESET;
         period_ff       <= PERIOD_RESET;
         stage_valid_ff  <= 1'b0;
         out_valid_ff    <= 1'b0;
         turn_on_next_ff <= 1'b0;
         round_time_ff   <= '0;
         digit_index_ff  <= '0;
         pending_ff      <= '0;
         shown_ff        <= '0;
         segment_ff      <= '0;
         digit_ff        <= '1;
         compare_ff      <= '0;
      end else begin
         duty_ff         <= duty_in;
         period_ff       <= period_in;
         stage_valid_ff  <= stage_valid_in;
         out_valid_ff    <= out_valid_in;
         turn_on_next_ff <= turn_on_next_in;
         round_time_ff   <= round_time_in;
         digit_index_ff  <= digit_index_in;
         pending_ff      <= pending_in;
         shown_ff        <= shown_in;
         segment_ff      <= segment_in;
         digit_ff        <= digit_in;
         compare_ff      <= compare_in;
      end
   end

   // input payload register
   always_ff @(posedge clock) begin
      if (accept) begin
         stage_mode_ff   <= req_ch.mode;
         stage_number_ff <= req_ch.number;
      end
   end

   // result channel: the hold registers are the result payload
   assign rsp_ch.valid           = out_valid_ff;
   assign rsp_ch.segment_lines   = segment_ff;
   assign rsp_ch.digit_enables_n = digit_ff;
   assign rsp_ch.next_compare    = compare_ff;

endmodule

### rtl/core/ssdm_checker.sv
// ----------------------------------------------------------------------------
// ssdm_checker
// port-level checks for the display driver, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ssdm_checker import ssdm_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [SEG_W-1:0]       segment_lines,
   input logic [DIGIT_COUNT-1:0] digit_enables_n,
   input logic [TICK_W-1:0]      next_compare
);

   // flattened result payload, stall and all-off conditions
   logic [SEG_W+DIGIT_COUNT+TICK_W-1:0] rsp_payload;
   logic                                rsp_stalled;
   logic                                all_off;

   assign rsp_payload = {segment_lines, digit_enables_n, next_compare};
   assign rsp_stalled = rsp_valid && !rsp_ready;
   assign all_off     = (digit_enables_n == '1);

   // no result right after reset
   `ASSERT_NEXT(a_idle_after_reset, clock, 1'b0, reset, !rsp_valid)

   // at most one digit lit at a time
   `ASSERT_IMPLY(a_one_digit, clock, reset, rsp_valid, $countones(~digit_enables_n) <= 1)

   // all digits off means blank segments
   `ASSERT_IMPLY(a_blank_when_off, clock, reset, rsp_valid && all_off, segment_lines == '0)

   // an empty result side never blocks the input
   `ASSERT_IMPLY(a_ready_when_empty, clock, reset, !rsp_valid, req_ready)

   // a stalled result holds its payload
   `ASSERT_NEXT(a_rsp_holds, clock, reset, rsp_stalled, rsp_valid && $stable(rsp_payload))

endmodule

bind seven_segment_display_multiplexer_unit ssdm_checker u_ssdm_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .segment_lines   (rsp_ch.segment_lines),
   .digit_enables_n (rsp_ch.digit_enables_n),
   .next_compare    (rsp_ch.next_compare)
);

### tb/seven_segment_display_multiplexer_unit_tb.sv
// ----------------------------------------------------------------------------
// seven_segment_display_multiplexer_unit_tb
// self-checking bench for the four-digit multiplexed display driver
//
// Sends load and timer compare items while the result side stalls at random.
// A cycle-free model of the scan logic predicts each segment drive, digit
// enable and next compare value, and every returned item is checked in order.
// duty_time and round_period are written over the csr port between phases,
// covering their extremes, zero period and random settings.
// ----------------------------------------------------------------------------
module seven_segment_display_multiplexer_unit_tb import ssdm_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT  = 2000;
   localparam int DRAIN_TICKS = 6;

   // segment glyphs for decimal digits, a in bit 7, dp in bit 0
   localparam logic [SEG_W-1:0] GLYPH [0:9] = '{
      8'hFC, 8'h60, 8'hDA, 8'hF2, 8'h66, 8'hB6, 8'hBE, 8'hE0, 8'hFE, 8'hF6
   };

   typedef struct packed {
      logic [SEG_W-1:0]       segments;
      logic [DIGIT_COUNT-1:0] enables_n;
      logic [TICK_W-1:0]      compare;
   } drive_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   ssdm_req_if req_ch ();
   ssdm_rsp_if rsp_ch ();

   seven_segment_display_multiplexer_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // display model state
   logic [TICK_W-1:0]      duty_cfg;
   logic [TICK_W-1:0]      period_cfg;
   logic                   on_next;
   logic [TICK_W-1:0]      round_start;
   logic [DIGIT_IDX_W-1:0] scan_pos;
   logic [SEG_W-1:0]       staged_glyphs [DIGIT_COUNT];
   logic [SEG_W-1:0]       lit_glyphs [DIGIT_COUNT];
   logic [SEG_W-1:0]       seg_hold;
   logic [DIGIT_COUNT-1:0] dig_hold;
   logic [TICK_W-1:0]      cmp_hold;

   drive_type   expected_drives [$];
   int unsigned mismatch_count;
   bit          gaps_on;
   int unsigned rsp_hold_request;

   // free-running clock
   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // predict the drive lines after one accepted item
   task automatic predict_drive(input mode_type m, input logic [NUMBER_W-1:0] num);
      logic [NUMBER_W-1:0] n;
      drive_type           d;
      if (m == MODE_LOAD) begin
         n = (num > MAX_NUMBER) ? MAX_NUMBER : num;
         staged_glyphs[0] = GLYPH[(n / 1000) % 10];
         staged_glyphs[1] = GLYPH[(n / 100) % 10];
         staged_glyphs[2] = GLYPH[(n / 10) % 10];
         staged_glyphs[3] = GLYPH[n % 10];
      end else if (on_next) begin
         // on event: new round, latch glyphs at scan start, light one digit
         on_next     = 1'b0;
         cmp_hold    = round_start + duty_cfg;
         round_start = round_start + period_cfg;
         if (scan_pos == 0)
            lit_glyphs = staged_glyphs;
         seg_hold = lit_glyphs[scan_pos];
         dig_hold = dig_hold & ~(DIGIT_COUNT'(1) << scan_pos);
         scan_pos = scan_pos + 1'b1;
      end else begin
         // off event: blank everything until the round time
         on_next  = 1'b1;
         cmp_hold = round_start;
         seg_hold = '0;
         dig_hold = '1;
      end
      d.segments  = seg_hold;
      d.enables_n = dig_hold;
      d.compare   = cmp_hold;
      expected_drives.push_back(d);
   endtask

   // send one item, with an occasional gap in front of it
   task automatic send_item(input mode_type m, input logic [NUMBER_W-1:0] num);
      int unsigned gap;
      if (gaps_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 10);
         @(negedge clock);
         req_ch.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_ch.valid  <= 1'b1;
      req_ch.mode   <= m;
      req_ch.number <= num;
      do @(posedge clock); while (!req_ch.ready);
      predict_drive(m, num);
   endtask

   // mostly compare events, with loads spread across the full number field
   task automatic send_random_item();
      logic [NUMBER_W-1:0] num;
      num = ($urandom_range(0, 1) == 0) ? NUMBER_W'($urandom_range(0, 9999))
                                        : NUMBER_W'($urandom);
      send_item(($urandom_range(0, 5) == 0) ? MODE_LOAD : MODE_COMPARE, num);
   endtask

   // drop valid and wait until every item has come back
   task automatic settle();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (expected_drives.size() != 0) @(posedge clock);
      repeat (DRAIN_TICKS) @(posedge clock);
   endtask

   // apb write, setup then access
   task automatic write_register(input reg_index_type idx, input logic [TICK_W-1:0] val);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= CSR_DATA_W'(val);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         REG_DUTY_TIME:    duty_cfg = val;
         REG_ROUND_PERIOD: period_cfg = val;
         default: ;
      endcase
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic set_timing(input logic [TICK_W-1:0] duty, input logic [TICK_W-1:0] period);
      write_register(REG_DUTY_TIME, duty);
      write_register(REG_ROUND_PERIOD, period);
   endtask

   // full scans around saturation, number field ignored on compares
   task automatic test_directed_values();
      send_item(MODE_COMPARE, '1);
      send_item(MODE_COMPARE, '0);
      send_item(MODE_LOAD, 14'd1234);
      repeat (8) send_item(MODE_COMPARE, NUMBER_W'($urandom));
      send_item(MODE_LOAD, 14'd16383);
      send_item(MODE_LOAD, 14'd5678);
      repeat (8) send_item(MODE_COMPARE, 14'h2AAA);
      send_item(MODE_LOAD, 14'd10000);
      send_item(MODE_LOAD, 14'd0);
      send_item(MODE_LOAD, 14'd9999);
      repeat (2) send_item(MODE_COMPARE, 14'h1555);
      settle();
   endtask

   // register extremes, zero period and out-of-range duty
   task automatic test_register_extremes();
      logic [TICK_W-1:0] duty_set   [7] = '{8'd0, 8'd255, 8'd3, 8'd249, 8'd0, 8'd255, 8'd100};
      logic [TICK_W-1:0] period_set [7] = '{8'd1, 8'd255, 8'd0, 8'd255, 8'd0, 8'd1, 8'd250};
      for (int i = 0; i < 7; i++) begin
         set_timing(duty_set[i], period_set[i]);
         repeat (40) send_random_item();
         settle();
      end
   endtask

   // result side held off long enough to back up the input
   task automatic test_output_backpressure();
      rsp_hold_request = 60;
      repeat (25) send_random_item();
      settle();
   endtask

   // sender stops until the block has drained, then resumes
   task automatic test_drain_pause();
      repeat (30) send_random_item();
      settle();
      repeat (30) send_random_item();
      settle();
   endtask

   task automatic test_random_traffic();
      for (int i = 0; i < 4; i++) begin
         set_timing(TICK_W'($urandom), TICK_W'($urandom));
         repeat (150) send_random_item();
         settle();
      end
   endtask

   // back-to-back traffic with no stalls on either side
   task automatic test_gap_free_tail();
      gaps_on = 1'b0;
      set_timing(TICK_W'($urandom), TICK_W'($urandom));
      repeat (120) send_random_item();
      settle();
   endtask

   // result side ready, random stalls plus a requested long hold
   initial begin : rsp_ready_drive
      int unsigned stall_left;
      logic        next_ready;
      stall_left   = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_request != 0) begin
            stall_left       = rsp_hold_request;
            rsp_hold_request = 0;
         end else if (stall_left == 0 && gaps_on && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(1, 10);
         end
         if (stall_left != 0) begin
            next_ready = 1'b0;
            stall_left--;
         end else begin
            next_ready = 1'b1;
         end
         rsp_ch.ready <= next_ready;
      end
   end

   // compare each returned item with the oldest prediction
   always @(posedge clock) begin
      drive_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_drives.size() == 0) begin
            mismatch_count++;
            $display("%0t ns: unexpected item seg %02h dig %01h cmp %02h", $time,
                     rsp_ch.segment_lines, rsp_ch.digit_enables_n, rsp_ch.next_compare);
         end else begin
            want = expected_drives.pop_front();
            if (rsp_ch.segment_lines !== want.segments) begin
               mismatch_count++;
               $display("%0t ns: segment_lines expected %02h actual %02h", $time,
                        want.segments, rsp_ch.segment_lines);
            end
            if (rsp_ch.digit_enables_n !== want.enables_n) begin
               mismatch_count++;
               $display("%0t ns: digit_enables_n expected %01h actual %01h", $time,
                        want.enables_n, rsp_ch.digit_enables_n);
            end
            if (rsp_ch.next_compare !== want.compare) begin
               mismatch_count++;
               $display("%0t ns: next_compare expected %02h actual %02h", $time,
                        want.compare, rsp_ch.next_compare);
            end
         end
      end
   end

   // watchdog on cycles with no handshake on either channel
   always @(posedge clock) begin
      int unsigned quiet_cycles;
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // reset, then the test sequence
   initial begin
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.mode      = MODE_LOAD;
      req_ch.number    = '0;
      csr_psel         = 1'b0;
      csr_penable      = 1'b0;
      csr_pwrite       = 1'b0;
      csr_paddr        = '0;
      csr_pwdata       = '0;
      mismatch_count   = 0;
      gaps_on          = 1'b1;
      rsp_hold_request = 0;
      duty_cfg         = DUTY_RESET;
      period_cfg       = PERIOD_RESET;
      on_next          = 1'b0;
      round_start      = '0;
      scan_pos         = '0;
      seg_hold         = '0;
      dig_hold         = '1;
      cmp_hold         = '0;
      for (int i = 0; i < DIGIT_COUNT; i++) begin
         staged_glyphs[i] = '0;
         lit_glyphs[i]    = '0;
      end
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_values();
      test_register_extremes();
      test_output_backpressure();
      test_drain_pause();
      test_random_traffic();
      test_gap_free_tail();

      if (mismatch_count == 0 && expected_drives.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

### seven_segment_display_multiplexer_unit.f
+incdir+rtl/core
rtl/core/ssdm_pkg.sv
rtl/core/ssdm_req_if.sv
rtl/core/ssdm_rsp_if.sv
rtl/core/seven_segment_display_multiplexer_unit.sv
rtl/core/ssdm_checker.sv
tb/seven_segment_display_multiplexer_unit_tb.sv
